// ===== rtl/prt_pkg.sv =====
// Shared constants, codes, types and a helper function of the packet receipt tracker.
package prt_pkg;

  localparam int PKT_W       = 16;
  localparam int MAX_TRACKED = 4096;
  localparam logic [PKT_W-1:0] SAT16 = 16'hFFFF;

  // The received map is kept as rows of ROW_BITS bits.
  localparam int ROW_BITS  = 32;
  localparam int ROW_OFF_W = $clog2(ROW_BITS);
  localparam int MAP_ROWS  = (MAX_TRACKED + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_EXTRA_ADDR = 3'd0;
  localparam logic [7:0] EXTRA_RESET = 8'd4;

  localparam logic REPLY_ACK    = 1'b0;
  localparam logic REPLY_GOTALL = 1'b1;

  typedef logic [PKT_W-1:0] pkt_t;

  typedef enum logic [2:0] {
    OP_RESET  = 3'd0,
    OP_DATA   = 3'd1,
    OP_SYNC   = 3'd2,
    OP_GOTALL = 3'd3,
    OP_FINAL  = 3'd4,
    OP_POLL   = 3'd5
  } prt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic do_reset;
    logic rd_pk;
    logic rd_cur;
    logic mark_pk;
    logic inorder;
    logic scan_eval;
    logic emit_ack;
    logic clr_cur;
    logic sync_load;
    logic gotall;
    logic repeat_ga;
    logic fin_op;
  } prt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    prt_op_e op;
    logic    accepted;
    logic    track;
    logic    pk_lt_et;
    logic    pk_eq_cur;
    logic    cur_lt_et;
    logic    complete;
    logic    pk_bit;
    logic    scan_more;
    logic    out_free;
  } prt_stat_t;

  // Index of the lowest set bit of a row word.
  function automatic logic [ROW_OFF_W-1:0] prt_first_one(input logic [ROW_BITS-1:0] v);
    logic [ROW_BITS-1:0]  lsb;
    logic [ROW_OFF_W-1:0] idx;
    lsb = v & (~v + {{(ROW_BITS-1){1'b0}}, 1'b1});
    idx = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (lsb[i]) idx = idx | ROW_OFF_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/prt_req_if.sv =====
// Request channel: valid/ready handshake carrying one tracker request.
interface prt_req_if;
  import prt_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] op;
  pkt_t       packet;
  pkt_t       total;
  logic       accepted;

  modport source (output valid, output op, output packet, output total, output accepted,
                  input ready);
  modport sink (input valid, input op, input packet, input total, input accepted,
                output ready);
endinterface

// ===== rtl/prt_rsp_if.sv =====
// Reply channel: valid/ready handshake carrying one tracker reply.
interface prt_rsp_if;
  import prt_pkg::*;

  logic valid;
  logic ready;
  logic reply_kind;
  pkt_t want_pkt;
  pkt_t xfer_total;

  modport source (output valid, output reply_kind, output want_pkt, output xfer_total,
                  input ready);
  modport sink (input valid, input reply_kind, input want_pkt, input xfer_total,
                output ready);
endinterface

// ===== rtl/prt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/prt_ctrl.sv =====
// Controller state machine: sequences map reads, marks, cursor scans and replies.
module prt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  prt_pkg::prt_stat_t stat_i,
  output prt_pkg::prt_cmd_t  cmd_o
);
  import prt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MARK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_ACK,
    S_CLR_CHK,
    S_CLR,
    S_SYNC,
    S_GOTALL,
    S_REPEAT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.op)
          OP_RESET: begin
            cmd_o.do_reset = 1'b1;
            state_d        = S_IDLE;
          end
          OP_DATA: begin
            priority if (stat_i.complete) begin
              state_d = S_REPEAT;
            end else if (!stat_i.accepted) begin
              state_d = S_ACK;
            end else if (!stat_i.track) begin
              cmd_o.inorder = 1'b1;
              state_d       = S_ACK;
            end else if (stat_i.pk_lt_et) begin
              cmd_o.rd_pk = 1'b1;
              state_d     = S_MARK;
            end else begin
              state_d = S_ACK;
            end
          end
          OP_SYNC:   state_d = S_SYNC;
          OP_GOTALL: state_d = S_GOTALL;
          OP_FINAL: begin
            cmd_o.fin_op = 1'b1;
            state_d      = S_IDLE;
          end
          OP_POLL:   state_d = stat_i.complete ? S_REPEAT : S_IDLE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_MARK: begin
        cmd_o.mark_pk = 1'b1;
        state_d = (!stat_i.pk_bit && stat_i.pk_eq_cur) ? S_SCAN_RD : S_ACK;
      end
      S_SCAN_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.scan_eval = 1'b1;
        state_d = stat_i.scan_more ? S_SCAN_RD : S_ACK;
      end
      S_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = S_CLR_CHK;
        end
      end
      S_CLR_CHK: begin
        if (stat_i.track && stat_i.cur_lt_et) begin
          cmd_o.rd_cur = 1'b1;
          state_d      = S_CLR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        cmd_o.clr_cur = 1'b1;
        state_d       = S_IDLE;
      end
      S_SYNC: begin
        if (stat_i.out_free) begin
          cmd_o.sync_load = 1'b1;
          state_d         = S_CLR_CHK;
        end
      end
      S_GOTALL: begin
        if (stat_i.out_free) begin
          cmd_o.gotall = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_REPEAT: begin
        if (stat_i.out_free) begin
          cmd_o.repeat_ga = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/prt_dp.sv =====
// Datapath: tracker state, received map with row valid bits, cursor scan and reply register.
module prt_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prt_pkg::prt_cmd_t  cmd_i,
  output prt_pkg::prt_stat_t stat_o,
  input  logic [2:0]         op_i,
  input  prt_pkg::pkt_t      packet_i,
  input  prt_pkg::pkt_t      total_i,
  input  logic               accepted_i,
  input  logic [7:0]         extra_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               reply_kind_o,
  output prt_pkg::pkt_t      want_pkt_o,
  output prt_pkg::pkt_t      xfer_total_o
);
  import prt_pkg::*;

  // Latched request
  prt_op_e op_q;
  pkt_t    pk_q, tot_q;
  logic    acc_q;

  // Tracker state
  pkt_t                cursor_q, cursor_d;
  pkt_t                count_q, count_d;
  pkt_t                et_q, et_d;
  logic                complete_q, complete_d;
  pkt_t                cn_q, cn_d;
  pkt_t                ct_q, ct_d;
  logic [7:0]          left_q, left_d;
  logic [MAP_ROWS-1:0] valid_q, valid_d;
  logic                rd_vld_q;

  // Reply register
  logic out_valid_q;
  logic out_kind_q;
  pkt_t out_next_q, out_total_q;

  logic                 ram_re, ram_we;
  logic [ROW_AW-1:0]    rd_row, wr_row, pk_row, cur_row;
  logic [ROW_BITS-1:0]  ram_rdata, rd_word, wr_word;
  logic [ROW_BITS-1:0]  low_mask, zero_bits;
  logic                 pk_bit, cur_bit, track, found, scan_more, out_free, load_out;
  logic [ROW_OFF_W-1:0] zero_idx;
  pkt_t                 first_pos, scan_cur, req_val, rep_val;
  logic [PKT_W:0]       next_base;

  assign pk_row  = pk_q[ROW_AW+ROW_OFF_W-1:ROW_OFF_W];
  assign cur_row = cursor_q[ROW_AW+ROW_OFF_W-1:ROW_OFF_W];
  assign track   = (et_q != '0) && ({1'b0, et_q} <= (PKT_W+1)'(MAX_TRACKED));

  // Map access
  assign ram_re  = cmd_i.rd_pk | cmd_i.rd_cur;
  assign rd_row  = cmd_i.rd_pk ? pk_row : cur_row;
  assign rd_word = rd_vld_q ? ram_rdata : '0;
  assign pk_bit  = rd_word[pk_q[ROW_OFF_W-1:0]];
  assign cur_bit = rd_word[cursor_q[ROW_OFF_W-1:0]];
  assign ram_we  = (cmd_i.mark_pk && !pk_bit) || (cmd_i.clr_cur && cur_bit);
  assign wr_row  = cmd_i.mark_pk ? pk_row : cur_row;
  assign wr_word = cmd_i.mark_pk
                 ? (rd_word | ({{(ROW_BITS-1){1'b0}}, 1'b1} << pk_q[ROW_OFF_W-1:0]))
                 : (rd_word & ~({{(ROW_BITS-1){1'b0}}, 1'b1} << cursor_q[ROW_OFF_W-1:0]));

  prt_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAP_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_row),
    .wdata_i (wr_word),
    .re_i    (ram_re),
    .raddr_i (rd_row),
    .rdata_o (ram_rdata)
  );

  // Cursor scan: first clear bit at or above the cursor within its row
  assign low_mask  = ~({ROW_BITS{1'b1}} << cursor_q[ROW_OFF_W-1:0]);
  assign zero_bits = ~(rd_word | low_mask);
  assign found     = |zero_bits;
  assign zero_idx  = prt_first_one(zero_bits);
  assign first_pos = {cursor_q[PKT_W-1:ROW_OFF_W], zero_idx};
  assign next_base = {1'b0, cursor_q[PKT_W-1:ROW_OFF_W], {ROW_OFF_W{1'b0}}}
                   + (PKT_W+1)'(ROW_BITS);
  assign scan_more = !found && (next_base < {1'b0, et_q});
  assign scan_cur  = found ? ((first_pos < et_q) ? first_pos : et_q)
                           : (scan_more ? next_base[PKT_W-1:0] : et_q);

  // Request to report
  assign req_val = (track && count_q >= et_q) ? et_q : cursor_q;
  assign rep_val = (et_q != '0 && req_val >= et_q) ? et_q - 16'd1 : req_val;

  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = cmd_i.emit_ack || cmd_i.sync_load || cmd_i.gotall
                 || (cmd_i.repeat_ga && left_q != '0);

  always_comb begin
    cursor_d   = cursor_q;
    count_d    = count_q;
    et_d       = et_q;
    complete_d = complete_q;
    cn_d       = cn_q;
    ct_d       = ct_q;
    left_d     = left_q;
    valid_d    = valid_q;
    if (cmd_i.do_reset) begin
      cursor_d   = '0;
      count_d    = '0;
      et_d       = tot_q;
      complete_d = 1'b0;
      cn_d       = '0;
      ct_d       = '0;
      left_d     = '0;
      valid_d    = '0;
    end
    if (ram_we) valid_d[wr_row] = 1'b1;
    if (cmd_i.mark_pk && !pk_bit && count_q != SAT16) count_d = count_q + 16'd1;
    if (cmd_i.inorder && pk_q == cursor_q) begin
      if (cursor_q != SAT16) cursor_d = cursor_q + 16'd1;
      if (count_q != SAT16) count_d = count_q + 16'd1;
    end
    if (cmd_i.scan_eval) cursor_d = scan_cur;
    if (cmd_i.emit_ack) begin
      cursor_d   = rep_val;
      complete_d = 1'b0;
    end
    if (cmd_i.clr_cur && cur_bit && count_q != '0) count_d = count_q - 16'd1;
    if (cmd_i.sync_load) begin
      complete_d = 1'b0;
      if (tot_q != '0) et_d = tot_q;
      cursor_d = pk_q;
    end
    if (cmd_i.gotall) begin
      if (!complete_q || cn_q != pk_q || ct_q != tot_q) left_d = extra_i;
      cn_d       = pk_q;
      ct_d       = tot_q;
      complete_d = 1'b1;
    end
    if (cmd_i.repeat_ga && left_q != '0) left_d = left_q - 8'd1;
    if (cmd_i.fin_op && complete_q) begin
      left_d     = '0;
      complete_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      count_q     <= '0;
      et_q        <= '0;
      complete_q  <= 1'b0;
      cn_q        <= '0;
      ct_q        <= '0;
      left_q      <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q   <= cursor_d;
      count_q    <= count_d;
      et_q       <= et_d;
      complete_q <= complete_d;
      cn_q       <= cn_d;
      ct_q       <= ct_d;
      left_q     <= left_d;
      valid_q    <= valid_d;
      if (ram_re) rd_vld_q <= valid_q[rd_row];
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= prt_op_e'(op_i);
      pk_q  <= packet_i;
      tot_q <= total_i;
      acc_q <= accepted_i;
    end
    if (load_out) begin
      priority if (cmd_i.emit_ack) begin
        out_kind_q  <= REPLY_ACK;
        out_next_q  <= rep_val;
        out_total_q <= et_q;
      end else if (cmd_i.sync_load) begin
        out_kind_q  <= REPLY_ACK;
        out_next_q  <= pk_q;
        out_total_q <= tot_q;
      end else if (cmd_i.gotall) begin
        out_kind_q  <= REPLY_GOTALL;
        out_next_q  <= pk_q;
        out_total_q <= tot_q;
      end else begin
        out_kind_q  <= REPLY_GOTALL;
        out_next_q  <= cn_q;
        out_total_q <= ct_q;
      end
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.accepted  = acc_q;
  assign stat_o.track     = track;
  assign stat_o.pk_lt_et  = pk_q < et_q;
  assign stat_o.pk_eq_cur = pk_q == cursor_q;
  assign stat_o.cur_lt_et = cursor_q < et_q;
  assign stat_o.complete  = complete_q;
  assign stat_o.pk_bit    = pk_bit;
  assign stat_o.scan_more = scan_more;
  assign stat_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = out_kind_q;
  assign want_pkt_o   = out_next_q;
  assign xfer_total_o = out_total_q;

`ifndef SYNTHESIS
  a_map_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_cur |-> track && (cursor_q < et_q))
    else $error("map read at cursor outside tracked range");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_eval |=> cursor_q <= et_q)
    else $error("cursor scan went past expected total");

  a_reply_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("reply register overwritten while full");

  a_reply_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_ack && (et_q != '0) |=> out_next_q < out_total_q)
    else $error("acknowledged request not below total");
`endif

endmodule

// ===== rtl/packet_receipt_tracker.sv =====
// Top level of the packet receipt tracker: request/reply channels, register port, core.
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+-----------------------------------------------
//  req_i    | in  | valid/ready        | op, packet, total, accepted
//  rsp_o    | out | valid/ready        | reply_kind, want_pkt, xfer_total
//  apb      | in  | psel/penable/pready| extra_gotall_repeats at byte address 0
//
//  One request at a time: a new request is taken only once the controller is back in idle;
//  a data request that fills the cursor's packet also scans the map row by row (32 packets
//  a row) through the single read port of the map.
//  rst_ni clears all tracker state at once: each map row has a valid bit, so no clearing
//  pass is needed, for rst_ni or for a reset request.
//  A full reply register stalls the controller only at the step that loads a reply.
module packet_receipt_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prt_req_if.sink                       req_i,
  prt_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prt_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import prt_pkg::*;

  prt_cmd_t   cmd;
  prt_stat_t  stat;
  logic [7:0] extra_q;
  logic       cfg_we;

  // Register port: zero wait states, one register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == CFG_EXTRA_ADDR);
  assign prdata = (paddr == CFG_EXTRA_ADDR) ? {24'd0, extra_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_q <= EXTRA_RESET;
    end else if (cfg_we) begin
      extra_q <= pwdata[7:0];
    end
  end

  // Controller: accepts a request only when idle, then steps the datapath.
  prt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: holds the map, cursor, counts, completion record and reply register.
  prt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (req_i.op),
    .packet_i     (req_i.packet),
    .total_i      (req_i.total),
    .accepted_i   (req_i.accepted),
    .extra_i      (extra_q),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .reply_kind_o (rsp_o.reply_kind),
    .want_pkt_o   (rsp_o.want_pkt),
    .xfer_total_o (rsp_o.xfer_total)
  );

endmodule

// ===== test/tb_packet_receipt_tracker.sv =====
// Self-checking testbench for the packet receipt tracker: random handshakes, APB setup, scoreboard.
module tb_packet_receipt_tracker;
  import prt_pkg::*;

  // Op codes beyond the package enum; the block must ignore these.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Longest quiet stretch after the last reply: a worst-case cursor scan plus margin.
  localparam int DRAIN_CYCLES   = 2 * MAP_ROWS + 40;
  // Cycles without any handshake or register access before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 160;

  typedef struct packed {
    logic [2:0] op;
    pkt_t       packet;
    pkt_t       total;
    logic       accepted;
  } tracker_req_t;

  typedef struct packed {
    logic kind;
    pkt_t nxt;
    pkt_t total;
  } tracker_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prt_req_if req_bus ();
  prt_rsp_if rsp_bus ();

  packet_receipt_tracker uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Tracker mirror: a private copy of the receive state, advanced once per
  // accepted request.
  // ---------------------------------------------------------------------------
  bit         rx_map [MAX_TRACKED];
  pkt_t       cursor;
  pkt_t       rx_count;
  pkt_t       exp_total;
  bit         complete;
  pkt_t       done_next;
  pkt_t       done_total;
  logic [7:0] gotall_left;
  logic [7:0] repeats_cfg = EXTRA_RESET;

  function automatic bit tracking();
    return (exp_total != 0) && (exp_total <= MAX_TRACKED);
  endfunction

  function automatic bit rx_got(input pkt_t p);
    if (p >= MAX_TRACKED) return 1'b0;
    return rx_map[p];
  endfunction

  // Advance the cursor past a run of packets already received.
  function automatic void skip_run();
    if (!tracking()) return;
    while (cursor < exp_total && rx_got(cursor)) cursor++;
  endfunction

  function automatic void count_arrival(input pkt_t p);
    if (tracking()) begin
      if (p < exp_total && !rx_got(p)) begin
        rx_map[p] = 1'b1;
        if (rx_count != SAT16) rx_count++;
        if (p == cursor) skip_run();
      end
    end else if (p == cursor) begin
      // in-order counting: cursor and count saturate
      if (cursor != SAT16) cursor++;
      if (rx_count != SAT16) rx_count++;
    end
  endfunction

  // Move the cursor to an externally reported missing packet.
  function automatic void resync(input pkt_t p, input pkt_t t);
    complete = 1'b0;
    if (t != 0) exp_total = t;
    cursor = p;
    if (tracking() && p < exp_total) begin
      if (rx_got(p)) begin
        rx_map[p] = 1'b0;
        if (rx_count != 0) rx_count--;
      end
      skip_run();
    end
  endfunction

  function automatic void clear_tracker(input pkt_t t);
    foreach (rx_map[i]) rx_map[i] = 1'b0;
    cursor      = '0;
    rx_count    = '0;
    exp_total   = t;
    complete    = 1'b0;
    done_next   = '0;
    done_total  = '0;
    gotall_left = '0;
  endfunction

  function automatic bit repeat_gotall(output tracker_reply_t rp);
    rp = '{REPLY_GOTALL, done_next, done_total};
    if (gotall_left == 0) return 1'b0;
    gotall_left--;
    return 1'b1;
  endfunction

  // Apply one request to the mirror; return 1 when it yields a reply.
  function automatic bit track_request(input tracker_req_t r, output tracker_reply_t rp);
    pkt_t want;
    pkt_t ask;
    rp = '{REPLY_ACK, '0, '0};
    case (r.op)
      OP_RESET: begin
        clear_tracker(r.total);
        return 1'b0;
      end
      OP_DATA: begin
        if (complete) return repeat_gotall(rp);
        if (r.accepted) count_arrival(r.packet);
        want = cursor;
        if (tracking() && rx_count >= exp_total) want = exp_total;
        ask = want;
        // clamp the request to the last packet of the transfer
        if (exp_total != 0 && want >= exp_total) ask = exp_total - 1'b1;
        rp = '{REPLY_ACK, ask, exp_total};
        resync(ask, exp_total);
        return 1'b1;
      end
      OP_SYNC: begin
        resync(r.packet, r.total);
        rp = '{REPLY_ACK, r.packet, r.total};
        return 1'b1;
      end
      OP_GOTALL: begin
        // reload the repeat budget only on a new or changed completion
        if (!complete || done_next != r.packet || done_total != r.total)
          gotall_left = repeats_cfg;
        done_next  = r.packet;
        done_total = r.total;
        complete   = 1'b1;
        rp = '{REPLY_GOTALL, r.packet, r.total};
        return 1'b1;
      end
      OP_FINAL: begin
        if (complete) begin
          gotall_left = '0;
          complete    = 1'b0;
        end
        return 1'b0;
      end
      OP_POLL: begin
        if (!complete) return 1'b0;
        return repeat_gotall(rp);
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: feed requests from the pending queue, with random gaps.
  // ---------------------------------------------------------------------------
  tracker_req_t   pending [$];
  tracker_req_t   in_flight;
  tracker_reply_t fresh_reply;
  tracker_reply_t replies_due [$];
  int             send_gap;
  bit             send_burst;
  int             reqs_done;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      send_gap = 0;
    end else if (!req_bus.valid || req_bus.ready) begin
      // the held request was taken at this edge: advance the mirror
      if (req_bus.valid) begin
        if (track_request(in_flight, fresh_reply)) replies_due.push_back(fresh_reply);
        reqs_done++;
      end
      if (send_gap > 0) begin
        send_gap--;
        req_bus.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        in_flight = pending.pop_front();
        req_bus.op       <= in_flight.op;
        req_bus.packet   <= in_flight.packet;
        req_bus.total    <= in_flight.total;
        req_bus.accepted <= in_flight.accepted;
        req_bus.valid    <= 1'b1;
        // toggle between gap-free stretches and randomly spaced ones
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 15);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reply monitor: stall at random, compare each reply with the oldest one due.
  // ---------------------------------------------------------------------------
  tracker_reply_t oldest_due;
  int             recv_stall;
  bit             recv_burst;
  int             replies_seen;
  int             errors;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          $error("reply with none due: reply_kind %0d want_pkt %0d xfer_total %0d",
                 rsp_bus.reply_kind, rsp_bus.want_pkt, rsp_bus.xfer_total);
          errors++;
        end else begin
          oldest_due = replies_due.pop_front();
          if (rsp_bus.reply_kind !== oldest_due.kind) begin
            $error("reply_kind: expected %0d, got %0d", oldest_due.kind, rsp_bus.reply_kind);
            errors++;
          end
          if (rsp_bus.want_pkt !== oldest_due.nxt) begin
            $error("want_pkt: expected %0d, got %0d", oldest_due.nxt, rsp_bus.want_pkt);
            errors++;
          end
          if (rsp_bus.xfer_total !== oldest_due.total) begin
            $error("xfer_total: expected %0d, got %0d",
                   oldest_due.total, rsp_bus.xfer_total);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Hang detection: any handshake or register access restarts the count.
  int idle_cycles;

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int counted_items;
  int settings_done;

  task automatic queue_req(input logic [2:0] op, input pkt_t pk, input pkt_t tot,
                           input logic acc);
    pending.push_back('{op, pk, tot, acc});
    if (op <= OP_POLL) counted_items++;
  endtask

  // Write the repeat budget while idle, then read it back.
  task automatic set_repeats(input logic [7:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_EXTRA_ADDR;
    pwdata  <= {24'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // write lands at this edge; go straight into the read setup
    repeats_cfg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== v) begin
      $error("extra_gotall_repeats: expected %0d, got %0d", v, prdata[7:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_done++;
  endtask

  // Hold until every request is taken and every reply is in, then let a
  // trailing reset or final request finish.
  task automatic settle_idle();
    while (pending.size() != 0 || req_bus.valid || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    // small tracked transfer: out-of-order arrival, duplicates, completion
    queue_req(OP_RESET, 16'hFFFF, 16'd4, 1'b1);
    queue_req(OP_DATA, 16'd0, 16'd0, 1'b1);
    queue_req(OP_DATA, 16'd2, 16'd0, 1'b1);
    queue_req(OP_DATA, 16'd1, 16'd0, 1'b1);          // cursor skips the received run
    queue_req(OP_DATA, 16'd1, 16'd0, 1'b0);          // not counted downstream
    queue_req(OP_DATA, 16'd9, 16'd0, 1'b1);          // beyond the total
    queue_req(OP_SYNC, 16'd2, 16'd0, 1'b0);          // zero total keeps the current one
    queue_req(OP_DATA, 16'd2, 16'd0, 1'b1);
    queue_req(OP_DATA, 16'd3, 16'd0, 1'b1);          // count reaches total: clamped request
    queue_req(OP_GOTALL, 16'd3, 16'd4, 1'b0);
    queue_req(OP_DATA, 16'd0, 16'd0, 1'b1);          // answered by a got-all repeat
    queue_req(OP_POLL, 16'd0, 16'd0, 1'b0);
    queue_req(OP_GOTALL, 16'd3, 16'd4, 1'b0);        // same values: budget not reloaded
    queue_req(OP_GOTALL, 16'd2, 16'd4, 1'b0);        // changed values: budget reloaded
    queue_req(OP_FINAL, 16'd0, 16'd0, 1'b0);
    queue_req(OP_FINAL, 16'd0, 16'd0, 1'b0);         // not complete any more
    queue_req(OP_POLL, 16'd0, 16'd0, 1'b0);          // poll with nothing to repeat
    queue_req(OP_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_req(OP_SPARE_7, 16'hFFFF, 16'hFFFF, 1'b1);
    // zero total: in-order counting, saturation at the top of the range
    queue_req(OP_RESET, 16'd0, 16'd0, 1'b0);
    queue_req(OP_SYNC, 16'hFFFF, 16'd0, 1'b0);
    queue_req(OP_DATA, 16'hFFFF, 16'd0, 1'b1);
    // full map, then one past the map
    queue_req(OP_RESET, 16'd0, MAX_TRACKED[PKT_W-1:0], 1'b0);
    queue_req(OP_DATA, 16'(MAX_TRACKED - 1), 16'd0, 1'b1);
    queue_req(OP_RESET, 16'd0, 16'(MAX_TRACKED + 1), 1'b0);
    queue_req(OP_DATA, 16'd0, 16'd0, 1'b1);
  endtask

  // One transfer from reset, usually to a final, or a burst of unstructured requests.
  task automatic queue_transfer();
    int   pick;
    int   t;
    int   n;
    int   c;
    int   seq;
    bit   trk;
    pkt_t p;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // noise: any op, any field value
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++) begin
        queue_req(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                  ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 64)),
                  1'($urandom_range(0, 1)));
      end
      return;
    end
    c = $urandom_range(0, 99);
    if (c < 60)      t = $urandom_range(1, 24);
    else if (c < 75) t = $urandom_range(25, 200);
    else if (c < 80) t = MAX_TRACKED;
    else if (c < 84) t = $urandom_range(201, MAX_TRACKED);
    else if (c < 92) t = 0;
    else             t = $urandom_range(MAX_TRACKED + 1, 65535);
    trk = (t != 0) && (t <= MAX_TRACKED);
    queue_req(OP_RESET, 16'($urandom_range(0, 65535)), 16'(t), 1'($urandom_range(0, 1)));
    n   = trk ? ((t + t / 2 + 2 < 48) ? t + t / 2 + 2 : 48) : $urandom_range(4, 30);
    seq = 0;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 80) begin
        if (!trk) begin
          p = ($urandom_range(0, 9) < 8) ? 16'(seq) : 16'(seq + 1);
          seq++;
        end else if ($urandom_range(0, 32) == 0) begin
          p = 16'(t + $urandom_range(0, 3));
        end else if (t <= 64 || $urandom_range(0, 4) == 0) begin
          p = 16'($urandom_range(0, t - 1));
        end else begin
          p = 16'(seq + $urandom_range(0, 3));
          seq++;
        end
        queue_req(OP_DATA, p, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 9) != 0));
      end else if (c < 88) begin
        p = trk ? 16'($urandom_range(0, t - 1)) : 16'(seq);
        queue_req(OP_SYNC, p, ($urandom_range(0, 1) != 0) ? 16'(t) : 16'd0, 1'b0);
      end else if (c < 93) begin
        queue_req(OP_POLL, 16'($urandom_range(0, 65535)), 16'd0, 1'b0);
      end else if (c < 96) begin
        queue_req(OP_FINAL, 16'd0, 16'd0, 1'b0);
      end else begin
        queue_req(OP_GOTALL, 16'($urandom_range(0, 65535)), 16'(t), 1'b0);
      end
    end
    // completion, a few repeats, usually the closing final
    p = (t == 0) ? 16'(seq) : 16'(t - 1);
    queue_req(OP_GOTALL, p, 16'(t), 1'b0);
    n = $urandom_range(0, 7);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9);
      if (c < 5)      queue_req(OP_DATA, 16'($urandom_range(0, 65535)), 16'd0, 1'b1);
      else if (c < 9) queue_req(OP_POLL, 16'd0, 16'd0, 1'b0);
      else            queue_req(OP_GOTALL, p, 16'(t), 1'b0);
    end
    if ($urandom_range(0, 9) < 7) queue_req(OP_FINAL, 16'd0, 16'd0, 1'b0);
  endtask

  logic [7:0] phase_repeats [5];
  int         phase_start;

  initial begin
    req_bus.valid    = 1'b0;
    req_bus.op       = OP_RESET;
    req_bus.packet   = '0;
    req_bus.total    = '0;
    req_bus.accepted = 1'b0;
    rsp_bus.ready    = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    clear_tracker('0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs with the reset value of the repeat budget
    queue_directed();
    settle_idle();

    // repeat budget per phase: none, the maximum, one, random, back to reset value
    phase_repeats[0] = 8'd0;
    phase_repeats[1] = 8'd255;
    phase_repeats[2] = 8'd1;
    phase_repeats[3] = 8'($urandom_range(2, 254));
    phase_repeats[4] = EXTRA_RESET;
    foreach (phase_repeats[k]) begin
      set_repeats(phase_repeats[k]);
      phase_start = counted_items;
      while (counted_items - phase_start < PHASE_ITEMS) queue_transfer();
      settle_idle();
    end

    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      errors++;
    end
    $display("covered %0d requests and %0d replies over %0d register settings",
             reqs_done, replies_seen, settings_done);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prt_pkg.sv
rtl/prt_req_if.sv
rtl/prt_rsp_if.sv
rtl/prt_ram.sv
rtl/prt_ctrl.sv
rtl/prt_dp.sv
rtl/packet_receipt_tracker.sv
test/tb_packet_receipt_tracker.sv
